@@ sv/accel_magnitude_to_color_defines.svh @@
// Assertion helpers for the accelerometer color block.
`ifndef ACCEL_MAGNITUDE_TO_COLOR_DEFINES_SVH
`define ACCEL_MAGNITUDE_TO_COLOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define AMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define AMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/amc_pkg.sv @@
`default_nettype none

package amc_pkg;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned SQ_STAGES = 16;
  localparam int unsigned FRAC_W    = 13;

  localparam logic [MAG_W-1:0] MAG_MAX = 16'd32768;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } amc_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] magnitude;
  } amc_out_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } amc_qstat_t;

endpackage

`default_nettype wire

@@ sv/amc_front.sv @@
`default_nettype none

module amc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  amc_pkg::amc_in_t             in_data_i,
  input  amc_pkg::amc_qstat_t          qstat_i,
  output logic                         push_o,
  output logic [amc_pkg::SUM_W-1:0]    push_data_o
);

  logic        s1_v_q, s2_v_q;
  logic [30:0] sqx_q, sqy_q, sqz_q;
  logic [amc_pkg::SUM_W-1:0] sum_q;
  logic signed [31:0] px, py, pz;
  logic [amc_pkg::QCNT_W:0] occ;
  logic accept;

  // reserve a queue slot for every word in flight here
  assign occ = {1'b0, qstat_i.count} + {{amc_pkg::QCNT_W{1'b0}}, s1_v_q}
             + {{amc_pkg::QCNT_W{1'b0}}, s2_v_q};
  assign in_ready_o = (occ < (amc_pkg::QCNT_W + 1)'(amc_pkg::QDEPTH));
  assign accept = in_valid_i & in_ready_o;

  assign px = in_data_i.accel_x * in_data_i.accel_x;
  assign py = in_data_i.accel_y * in_data_i.accel_y;
  assign pz = in_data_i.accel_z * in_data_i.accel_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= px[30:0];
    sqy_q <= py[30:0];
    sqz_q <= pz[30:0];
    sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q} + {1'b0, sqz_q};
  end

  assign push_o      = s2_v_q;
  assign push_data_o = sum_q;

endmodule

`default_nettype wire

@@ sv/amc_fifo.sv @@
`default_nettype none

module amc_fifo (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push_i,
  input  wire [amc_pkg::SUM_W-1:0]     push_data_i,
  input  wire                          pop_i,
  output logic [amc_pkg::SUM_W-1:0]    pop_data_o,
  output amc_pkg::amc_qstat_t          qstat_o
);

  logic [amc_pkg::SUM_W-1:0]  mem_q [amc_pkg::QDEPTH];
  logic [amc_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [amc_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  assign pop_data_o    = mem_q[rptr_q];
  assign qstat_o.count = cnt_q;
  assign qstat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ sv/amc_back.sv @@
`default_nettype none

module amc_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  amc_pkg::amc_qstat_t          qstat_i,
  output logic                         pop_o,
  input  wire [amc_pkg::SUM_W-1:0]     pop_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output amc_pkg::amc_out_t            out_data_o
);

  localparam logic [2:0] SEG_BLUE_CYAN   = 3'd0;
  localparam logic [2:0] SEG_CYAN_GREEN  = 3'd1;
  localparam logic [2:0] SEG_GREEN_YEL   = 3'd2;
  localparam logic [2:0] SEG_YEL_RED     = 3'd3;

  localparam int unsigned NS = amc_pkg::SQ_STAGES;

  logic                           adv;
  logic [NS-1:0]                  v_q;
  logic [17:0]                    rem_q  [NS];
  logic [amc_pkg::MAG_W-1:0]      root_q [NS];
  logic [amc_pkg::SUM_W-1:0]      rad_q  [NS];

  logic                           out_v_q;
  amc_pkg::amc_out_t              out_q, out_d;

  assign adv   = !out_v_q || out_ready_i;
  assign pop_o = adv && !qstat_i.empty;

  // one root bit per stage, radicand consumed two bits at a time from the top
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                       v_in;
    logic [17:0]                rem_in, rem_d;
    logic [amc_pkg::MAG_W-1:0]  root_in, root_d;
    logic [amc_pkg::SUM_W-1:0]  rad_in;
    logic [19:0]                rem_sh, trial;

    if (k == 0) begin : g_first
      assign v_in    = pop_o;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = pop_data_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[amc_pkg::SUM_W-1 -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = 18'(rem_sh - trial);
        root_d = {root_in[amc_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[17:0];
        root_d = {root_in[amc_pkg::MAG_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[amc_pkg::SUM_W-3:0], 2'b00};
      end
    end
  end

  // (x * 255) >> 13 for x up to 8192
  function automatic logic [7:0] ramp(input logic [13:0] x);
    logic [21:0] p;
    p = {x, 8'h00} - {8'h00, x};
    return p[20:13];
  endfunction

  logic [amc_pkg::MAG_W-1:0]  root, mag;
  logic [amc_pkg::FRAC_W-1:0] frac;
  logic [13:0]                up, down;

  always_comb begin
    root = root_q[NS-1];
    mag  = (root > amc_pkg::MAG_MAX) ? amc_pkg::MAG_MAX : root;
    frac = mag[amc_pkg::FRAC_W-1:0];
    up   = {1'b0, frac};
    down = 14'd8192 - {1'b0, frac};
    out_d.magnitude = mag;
    unique case (mag[amc_pkg::MAG_W-1:amc_pkg::FRAC_W])
      SEG_BLUE_CYAN: begin
        out_d.red = 8'd0; out_d.green = ramp(up); out_d.blue = 8'd255;
      end
      SEG_CYAN_GREEN: begin
        out_d.red = 8'd0; out_d.green = 8'd255; out_d.blue = ramp(down);
      end
      SEG_GREEN_YEL: begin
        out_d.red = ramp(up); out_d.green = 8'd255; out_d.blue = 8'd0;
      end
      SEG_YEL_RED: begin
        out_d.red = 8'd255; out_d.green = ramp(down); out_d.blue = 8'd0;
      end
      default: begin
        out_d.red = 8'd255; out_d.green = 8'd0; out_d.blue = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sv/accel_magnitude_to_color.sv @@
// Accelerometer magnitude to gradient color.
// Input channel in_valid_i/in_ready_o carries one word: a signed 16-bit x, y, z
// sample at 8192 counts per g. Output channel out_valid_o/out_ready_i returns
// one word per sample: red, green, blue and the magnitude in Q3.13 g,
// clamped at 4.0 g, in input order.
// Throughput: one word per cycle while out_ready_i does not stall the output.
// From input accept to output valid: the squares register at the accept edge,
// then the sum register, the queue, sixteen square-root stages (one root bit
// each) and one color stage.
// The front issues into a four-word queue and only accepts while a queue
// slot is reserved for every word it holds, so in_ready_o depends only on
// registered state and never on out_ready_i.
// When the receiver stalls, the root pipeline and output register hold,
// the queue fills, and in_ready_o drops once the reserved slots run out.
// Reset empties the queue and clears all valid flags; no clearing pass.
`default_nettype none

`include "accel_magnitude_to_color_defines.svh"

module accel_magnitude_to_color (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  amc_pkg::amc_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output amc_pkg::amc_out_t  out_data_o
);

  logic                       push, pop;
  logic [amc_pkg::SUM_W-1:0]  push_data, pop_data;
  amc_pkg::amc_qstat_t        qstat;

  amc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  amc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  amc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `AMC_ASSERT_IMP(a_no_overflow, push, qstat.count < amc_pkg::QCNT_W'(amc_pkg::QDEPTH), "queue overflow")
  `AMC_ASSERT_IMP(a_no_underrun, pop, !qstat.empty, "pop from empty queue")
  `AMC_ASSERT_NXT(a_stall_holds_queue, out_valid_o && !out_ready_i, qstat.count >= $past(qstat.count), "queue drained during output stall")

endmodule

`default_nettype wire
